FILE: rtl/core/tzl_pkg.sv
`default_nettype none

package tzl_pkg;

    // table depth used when the top level is not overridden
    localparam int DEFAULT_MAX_TRANSITIONS = 256;

    // field widths
    localparam int TIME_W  = 40;
    localparam int OFF_W   = 18;
    localparam int INDEX_W = 9;

    // width of the shared three-term adder, holds time - time + offset
    localparam int SUM_W = 42;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_UTC    = 2'd2,
        MODE_LOCAL  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE_ADDR,
        ST_PROBE_CMP,
        ST_FETCH_CUR,
        ST_FETCH_NEXT,
        ST_FETCH_PREV,
        ST_GAP,
        ST_REPEAT,
        ST_RESULT
    } state_t;

    // one stored transition
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [OFF_W-1:0]  offset;
        logic              dst;
    } entry_t;

    // operand signs for the shared adder
    typedef struct packed {
        logic neg_b;
        logic neg_c;
    } sum_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/tzl_sum3.sv
`default_nettype none

module tzl_sum3 import tzl_pkg::*;
(
    input  sum_ctl_t                ctl,
    input  logic signed [SUM_W-1:0] a,
    input  logic signed [SUM_W-1:0] b,
    input  logic signed [SUM_W-1:0] c,
    output logic                    negative
);

    logic signed [SUM_W-1:0] b_term;
    logic signed [SUM_W-1:0] c_term;
    logic signed [SUM_W-1:0] total;

    // a +/- b +/- c, only the sign is needed by the sequencer
    assign b_term   = ctl.neg_b ? -b : b;
    assign c_term   = ctl.neg_c ? -c : c;
    assign total    = a + b_term + c_term;
    assign negative = total[SUM_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/tz_transition_lookup_unit.sv
// Time-zone transition table with UTC and local-time lookup.
// Input channel (in_valid / in_stall) carries one word: mode, time_seconds,
// phase_offset_in, dst_in. Mode clear empties the table, mode append stores
// one transition at the end unless full, UTC and local run a binary search.
// Output channel (out_valid / out_stall) returns exactly one word per input.
// The block takes one input word at a time; in_stall stays high from the
// accept until the result has moved into the output register.
// A query makes at most ceil(log2(entries+1)) probes; clear and append go
// straight to the result. The next word is taken in the idle state that
// follows each result. Each probe reads the memory and then compares
// through the single shared adder; the local query adds reads of the
// neighboring entries and the gap and repeat checks on the same adder.
// A new word is accepted while a finished result still waits in the output
// register; when out_stall holds, the next result waits until it drains.
// pre_utc_offset is written through cfg_write_en / cfg_write_data by the user
// only while idle, unenforced. Reset empties the table, clears pre_utc_offset;
// table contents are not cleared, only entries below the fill count are used.
`default_nettype none

module tz_transition_lookup_unit import tzl_pkg::*;
#(
    parameter int MAX_TRANSITIONS = DEFAULT_MAX_TRANSITIONS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration
    input  wire logic                      cfg_write_en,
    input  wire logic signed [OFF_W-1:0]   cfg_write_data,
    // input channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                mode,
    input  wire logic signed [TIME_W-1:0]  time_seconds,
    input  wire logic signed [OFF_W-1:0]   phase_offset_in,
    input  wire logic                      dst_in,
    // output channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [INDEX_W-1:0]      first_index,
    output logic signed [INDEX_W-1:0]      second_index,
    output logic                           valid_time,
    output logic signed [OFF_W-1:0]        phase_offset_out,
    output logic                           is_dst,
    output logic                           table_full
);

    localparam int IDX_W = $clog2(MAX_TRANSITIONS);
    localparam int CNT_W = $clog2(MAX_TRANSITIONS + 1);
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_TRANSITIONS);
    localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO       = CNT_W'(2);

    // control registers
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;     // search lower bound plus one
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic signed [OFF_W-1:0]  pre_reg;
    logic                     out_valid_reg, out_valid_next;

    // payload registers
    logic [IDX_W-1:0]         mid_reg, mid_next;
    mode_t                    mode_reg, mode_next;
    logic signed [TIME_W-1:0] time_reg, time_next;
    logic                     gap_reg, gap_next;
    logic                     rep_reg, rep_next;
    logic                     full_reg, full_next;
    logic signed [TIME_W-1:0] cur_time_reg;
    logic signed [OFF_W-1:0]  cur_off_reg;
    logic                     cur_dst_reg;
    logic signed [TIME_W-1:0] nxt_time_reg;
    logic signed [OFF_W-1:0]  nxt_off_reg;
    logic signed [OFF_W-1:0]  prev_off_reg;
    logic                     prev_dst_reg;

    // output registers
    logic [INDEX_W-1:0]       first_reg, first_next;
    logic [INDEX_W-1:0]       second_reg, second_next;
    logic                     valid_time_reg, valid_time_next;
    logic signed [OFF_W-1:0]  off_out_reg, off_out_next;
    logic                     dst_out_reg, dst_out_next;
    logic                     full_out_reg, full_out_next;

    // transition memory
    entry_t                   mem [MAX_TRANSITIONS];
    entry_t                   rd_data_reg;
    entry_t                   wr_data;
    logic [IDX_W-1:0]         rd_addr;
    logic                     mem_we;

    // misc
    logic                     in_accept;
    logic                     out_load;
    logic                     ld_cur, ld_nxt, ld_prev;
    logic [CNT_W:0]           mid_sum;
    logic [IDX_W-1:0]         mid_idx;
    logic                     has_cur, has_next, has_prev;
    logic signed [OFF_W-1:0]  cur_off_v;
    logic signed [OFF_W-1:0]  prev_off_v;

    // shared adder operands
    sum_ctl_t                 sum_ctl;
    logic signed [SUM_W-1:0]  sum_a, sum_b, sum_c;
    logic                     sum_neg;

    function automatic logic [INDEX_W-1:0] index_code(input logic none,
                                                      input logic [CNT_W-1:0] num);
        logic [31:0] wide;
        wide = 32'(num);
        return none ? '1 : wide[INDEX_W-1:0];
    endfunction

    tzl_sum3 u_sum3 (
        .ctl      (sum_ctl),
        .a        (sum_a),
        .b        (sum_b),
        .c        (sum_c),
        .negative (sum_neg)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // search window and neighbor presence
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W + 1)'(1);
    assign mid_idx    = mid_sum[IDX_W:1];
    assign has_cur    = (lo_reg != '0);
    assign has_next   = (lo_reg < count_reg);
    assign has_prev   = (lo_reg > ONE);
    assign cur_off_v  = has_cur ? cur_off_reg : pre_reg;
    assign prev_off_v = has_prev ? prev_off_reg : pre_reg;

    assign wr_data = '{start_time: time_seconds, offset: phase_offset_in, dst: dst_in};

    // shared adder operand selection
    always_comb
    begin
        case (state_reg)
            ST_PROBE_CMP:
            begin
                // key < time  <=>  t - off - time < 0
                sum_ctl = '{neg_b: 1'b1, neg_c: 1'b1};
                sum_a   = SUM_W'(time_reg);
                sum_b   = (mode_reg == MODE_LOCAL) ?
                          SUM_W'($signed(rd_data_reg.offset)) : '0;
                sum_c   = SUM_W'($signed(rd_data_reg.start_time));
            end
            ST_GAP:
            begin
                // next time - t + current offset < 0
                sum_ctl = '{neg_b: 1'b1, neg_c: 1'b0};
                sum_a   = SUM_W'(nxt_time_reg);
                sum_b   = SUM_W'(time_reg);
                sum_c   = SUM_W'(cur_off_v);
            end
            default:
            begin
                // t - current time - previous offset < 0
                sum_ctl = '{neg_b: 1'b1, neg_c: 1'b1};
                sum_a   = SUM_W'(time_reg);
                sum_b   = SUM_W'(cur_time_reg);
                sum_c   = SUM_W'(prev_off_v);
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        mode_next       = mode_reg;
        time_next       = time_reg;
        gap_next        = gap_reg;
        rep_next        = rep_reg;
        full_next       = full_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_load        = 1'b0;
        ld_cur          = 1'b0;
        ld_nxt          = 1'b0;
        ld_prev         = 1'b0;
        mem_we          = 1'b0;
        rd_addr         = '0;
        first_next      = first_reg;
        second_next     = second_reg;
        valid_time_next = valid_time_reg;
        off_out_next    = off_out_reg;
        dst_out_next    = dst_out_reg;
        full_out_next   = full_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next = mode_t'(mode);
                    time_next = time_seconds;
                    gap_next  = 1'b0;
                    rep_next  = 1'b0;
                    full_next = 1'b0;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    case (mode_t'(mode))
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_RESULT;
                        end
                        MODE_APPEND:
                        begin
                            if (count_reg >= MAX_COUNT)
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + ONE;
                            end
                            state_next = ST_RESULT;
                        end
                        default:
                        begin
                            state_next = ST_PROBE_ADDR;
                        end
                    endcase
                end
            end

            // read the middle entry while the window is not empty
            ST_PROBE_ADDR:
            begin
                if (hi_reg > lo_reg)
                begin
                    rd_addr    = mid_idx;
                    mid_next   = mid_idx;
                    state_next = ST_PROBE_CMP;
                end
                else
                begin
                    state_next = ST_FETCH_CUR;
                end
            end

            ST_PROBE_CMP:
            begin
                if (sum_neg)
                    hi_next = CNT_W'(mid_reg);
                else
                    lo_next = CNT_W'(mid_reg) + ONE;
                state_next = ST_PROBE_ADDR;
            end

            ST_FETCH_CUR:
            begin
                rd_addr    = IDX_W'(lo_reg - ONE);
                state_next = ST_FETCH_NEXT;
            end

            ST_FETCH_NEXT:
            begin
                ld_cur  = 1'b1;
                rd_addr = IDX_W'(lo_reg);
                if (mode_reg == MODE_LOCAL)
                    state_next = ST_FETCH_PREV;
                else
                    state_next = ST_RESULT;
            end

            ST_FETCH_PREV:
            begin
                ld_nxt     = 1'b1;
                rd_addr    = IDX_W'(lo_reg - TWO);
                state_next = ST_GAP;
            end

            // spring-forward gap against the following transition
            ST_GAP:
            begin
                ld_prev    = 1'b1;
                gap_next   = has_next && (nxt_off_reg > cur_off_v) && sum_neg;
                state_next = ST_REPEAT;
            end

            // fall-back repeat against the preceding phase
            ST_REPEAT:
            begin
                rep_next   = !gap_reg && has_cur && (prev_off_v > cur_off_reg) && sum_neg;
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    full_out_next  = full_reg;
                    if (mode_reg == MODE_CLEAR || mode_reg == MODE_APPEND)
                    begin
                        first_next      = '1;
                        second_next     = '1;
                        valid_time_next = 1'b1;
                        off_out_next    = '0;
                        dst_out_next    = 1'b0;
                    end
                    else if (gap_reg)
                    begin
                        first_next      = '1;
                        second_next     = '1;
                        valid_time_next = 1'b0;
                        off_out_next    = pre_reg;
                        dst_out_next    = 1'b0;
                    end
                    else
                    begin
                        valid_time_next = 1'b1;
                        second_next     = index_code(!has_cur, lo_reg - ONE);
                        if (rep_reg)
                        begin
                            first_next   = index_code(!has_prev, lo_reg - TWO);
                            off_out_next = prev_off_v;
                            dst_out_next = has_prev && prev_dst_reg;
                        end
                        else
                        begin
                            first_next   = index_code(!has_cur, lo_reg - ONE);
                            off_out_next = cur_off_v;
                            dst_out_next = has_cur && cur_dst_reg;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            pre_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
                pre_reg <= cfg_write_data;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        mid_reg  <= mid_next;
        mode_reg <= mode_next;
        time_reg <= time_next;
        gap_reg  <= gap_next;
        rep_reg  <= rep_next;
        full_reg <= full_next;
        if (ld_cur)
        begin
            cur_time_reg <= $signed(rd_data_reg.start_time);
            cur_off_reg  <= $signed(rd_data_reg.offset);
            cur_dst_reg  <= rd_data_reg.dst;
        end
        if (ld_nxt)
        begin
            nxt_time_reg <= $signed(rd_data_reg.start_time);
            nxt_off_reg  <= $signed(rd_data_reg.offset);
        end
        if (ld_prev)
        begin
            prev_off_reg <= $signed(rd_data_reg.offset);
            prev_dst_reg <= rd_data_reg.dst;
        end
        if (out_load)
        begin
            first_reg      <= first_next;
            second_reg     <= second_next;
            valid_time_reg <= valid_time_next;
            off_out_reg    <= off_out_next;
            dst_out_reg    <= dst_out_next;
            full_out_reg   <= full_out_next;
        end
    end

    // transition memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[IDX_W-1:0]] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // output word
    assign out_valid        = out_valid_reg;
    assign first_index      = $signed(first_reg);
    assign second_index     = $signed(second_reg);
    assign valid_time       = valid_time_reg;
    assign phase_offset_out = off_out_reg;
    assign is_dst           = dst_out_reg;
    assign table_full       = full_out_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("entry count above table depth");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && mode == MODE_APPEND && count_reg < MAX_COUNT)
        |=> (count_reg == $past(count_reg) + ONE))
        else $error("append did not advance the entry count");

    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE_CMP) |-> (lo_reg < hi_reg))
        else $error("search window empty during a probe");

    a_gap_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && gap_reg && mode_reg == MODE_LOCAL)
        |=> (out_valid_reg && !valid_time_reg && first_reg == '1))
        else $error("gap result not flagged invalid");

endmodule

`default_nettype wire
